@@ rtl/rds_pkg.sv @@
// package for the reaction-diffusion rate block: constants, types, commands
// no dependencies
package rds_pkg;
    localparam int MAX_COLS_D    = 128;
    localparam int MAX_ROWS_D    = 512;
    localparam int VALUE_WIDTH_D = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int COL_W         = 7;
    localparam int ROW_W         = 9;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_CONST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_SLOPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VARY_BETA  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd7;

    // stencil neighbor codes
    localparam logic [2:0] NB_C = 3'd0;
    localparam logic [2:0] NB_W = 3'd1;
    localparam logic [2:0] NB_E = 3'd2;
    localparam logic [2:0] NB_S = 3'd3;
    localparam logic [2:0] NB_N = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;   // latch input item
        logic       wr_cell;   // write the memory
        logic       rd_en;     // issue a neighbor read
        logic [2:0] rd_sel;    // which neighbor, NB_* code
        logic       lat_en;    // latch read data of previous read
        logic [2:0] lat_sel;
        logic       calc_a;    // product stage
        logic       calc_b;    // second stage
        logic       calc_c;    // final round/saturate
    } t_cmd;

    typedef struct packed {
        logic is_eval;
        logic out_busy;
    } t_sts;
endpackage

@@ rtl/rds_ram.sv @@
// generic single-port write, single read RAM with registered read
// no dependencies
module rds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

@@ rtl/rds_ctrl.sv @@
// controller state machine for the rate block
// depends on rds_pkg
module rds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rds_pkg::t_sts i_sts,
    output rds_pkg::t_cmd o_cmd
);
    import rds_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD0  = 9'b000000010,
        S_RD1  = 9'b000000100,
        S_RD2  = 9'b000001000,
        S_RD3  = 9'b000010000,
        S_RD4  = 9'b000100000,
        S_CA   = 9'b001000000,
        S_CB   = 9'b010000000,
        S_CC   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = w_acc;
                if (w_acc) n_state = S_RD0;
            end
            S_RD0: begin
                if (i_sts.is_eval) begin
                    o_cmd.rd_en = 1'b1; o_cmd.rd_sel = NB_C; n_state = S_RD1;
                end else begin
                    o_cmd.wr_cell = 1'b1; n_state = S_IDLE;
                end
            end
            S_RD1: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = NB_W;
                o_cmd.lat_en = 1'b1; o_cmd.lat_sel = NB_C; n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = NB_E;
                o_cmd.lat_en = 1'b1; o_cmd.lat_sel = NB_W; n_state = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = NB_S;
                o_cmd.lat_en = 1'b1; o_cmd.lat_sel = NB_E; n_state = S_RD4;
            end
            S_RD4: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = NB_N;
                o_cmd.lat_en = 1'b1; o_cmd.lat_sel = NB_S; n_state = S_CA;
            end
            S_CA: begin
                o_cmd.lat_en = 1'b1; o_cmd.lat_sel = NB_N;
                o_cmd.calc_a = 1'b1; n_state = S_CB;
            end
            S_CB: begin
                o_cmd.calc_b = 1'b1; n_state = S_CC;
            end
            S_CC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.calc_c = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.capture) else $error("capture while busy");
    a_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.calc_c |-> !i_sts.out_busy) else $error("result overwrite");
endmodule

@@ rtl/rds_dp.sv @@
// datapath: config registers, cell memory, stencil arithmetic, output register
// depends on rds_pkg and rds_ram
module rds_dp #(
    parameter int MAX_COLS    = rds_pkg::MAX_COLS_D,
    parameter int MAX_ROWS    = rds_pkg::MAX_ROWS_D,
    parameter int VALUE_WIDTH = rds_pkg::VALUE_WIDTH_D
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [VALUE_WIDTH-1:0]           i_cfg_data,
    input  logic                             i_req_type,
    input  logic [rds_pkg::COL_W-1:0]        i_col,
    input  logic [rds_pkg::ROW_W-1:0]        i_row,
    input  logic signed [VALUE_WIDTH-1:0]    i_u_value,
    input  logic signed [VALUE_WIDTH-1:0]    i_v_value,
    input  logic                             i_clamp_edges,
    input  rds_pkg::t_cmd                    i_cmd,
    output rds_pkg::t_sts                    o_sts,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic signed [VALUE_WIDTH-1:0]    o_rate_u,
    output logic signed [VALUE_WIDTH-1:0]    o_rate_v,
    output logic                             o_overflow
);
    import rds_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int F    = VW - 8;
    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int AW   = CW + RW;
    localparam int CNW  = $clog2(MAX_COLS + 1);
    localparam int RNW  = $clog2(MAX_ROWS + 1);
    localparam int PW   = 2 * VW + 8;   // product width
    localparam int AccW = 2 * VW + 12;
    localparam logic [VW-1:0] EPS = VW'(((64'd9 << F) + 64'd12) / 64'd25);

    // configuration registers
    logic signed [VW-1:0] r_cx, r_cy, r_bc, r_bb, r_bs;
    logic                 r_vary;
    logic [7:0]           r_cols;
    logic [9:0]           r_rows;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_bc <= '0; r_bb <= '0; r_bs <= '0;
            r_vary <= 1'b0; r_cols <= 8'd128; r_rows <= 10'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEF_X:     r_cx <= $signed(i_cfg_data);
                REG_COEF_Y:     r_cy <= $signed(i_cfg_data);
                REG_BETA_CONST: r_bc <= $signed(i_cfg_data);
                REG_BETA_BASE:  r_bb <= $signed(i_cfg_data);
                REG_BETA_SLOPE: r_bs <= $signed(i_cfg_data);
                REG_VARY_BETA:  r_vary <= i_cfg_data[0];
                REG_GRID_COLS:  r_cols <= i_cfg_data[7:0];
                REG_GRID_ROWS:  r_rows <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // clamped grid size
    logic [CNW-1:0] w_nc;
    logic [RNW-1:0] w_nr;
    always_comb begin
        if (r_cols < 8'd3) w_nc = CNW'(3);
        else if (32'(r_cols) > MAX_COLS) w_nc = CNW'(MAX_COLS);
        else w_nc = CNW'(r_cols);
        if (r_rows < 10'd3) w_nr = RNW'(3);
        else if (32'(r_rows) > MAX_ROWS) w_nr = RNW'(MAX_ROWS);
        else w_nr = RNW'(r_rows);
    end

    // captured item
    logic                 r_type, r_clamp;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic signed [VW-1:0] r_uin, r_vin;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_req_type; r_col <= i_col; r_row <= i_row;
            r_uin <= i_u_value; r_vin <= i_v_value; r_clamp <= i_clamp_edges;
        end
    end

    // neighbor indexes
    logic [31:0] w_c, w_r, w_cw, w_ce, w_rs, w_rn;
    logic        w_inside, w_wr_ok, w_zero;
    always_comb begin
        w_c  = 32'(r_col);
        w_r  = 32'(r_row);
        w_cw = (w_c == 0) ? 32'(w_nc) - 1 : w_c - 1;
        w_ce = (w_c + 1 == 32'(w_nc)) ? 32'd0 : w_c + 1;
        w_rs = (w_r == 0) ? 32'(w_nr) - 1 : w_r - 1;
        w_rn = (w_r + 1 == 32'(w_nr)) ? 32'd0 : w_r + 1;
        w_inside = (w_c < 32'(w_nc)) && (w_r < 32'(w_nr));
        w_zero = !w_inside || (r_clamp && (w_r == 0 || w_r == 32'(w_nr) - 1));
        w_wr_ok = (w_c < MAX_COLS) && (w_r < MAX_ROWS);
    end

    logic [31:0] w_rc, w_rr;
    always_comb begin
        case (i_cmd.rd_sel)
            NB_W:    begin w_rc = w_cw; w_rr = w_r; end
            NB_E:    begin w_rc = w_ce; w_rr = w_r; end
            NB_S:    begin w_rc = w_c;  w_rr = w_rs; end
            NB_N:    begin w_rc = w_c;  w_rr = w_rn; end
            default: begin w_rc = w_c;  w_rr = w_r; end
        endcase
    end

    // memory spans the full row and column index space
    logic [2*VW-1:0] w_rdata;
    rds_ram #(.WIDTH(2 * VW), .DEPTH(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_cell && w_wr_ok),
        .i_waddr({w_r[RW-1:0], w_c[CW-1:0]}),
        .i_wdata({r_uin, r_vin}),
        .i_re   (i_cmd.rd_en),
        .i_raddr(AW'({w_rr[RW-1:0], w_rc[CW-1:0]})),
        .o_rdata(w_rdata)
    );

    assign o_sts.is_eval  = r_type;
    assign o_sts.out_busy = o_out_valid && i_out_stall;

    // latch neighbor data
    logic signed [VW-1:0] r_u, r_v, r_uw, r_ue, r_us, r_un;
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_en) begin
            case (i_cmd.lat_sel)
                NB_C: begin r_u <= w_rdata[2*VW-1:VW]; r_v <= w_rdata[VW-1:0]; end
                NB_W: r_uw <= w_rdata[2*VW-1:VW];
                NB_E: r_ue <= w_rdata[2*VW-1:VW];
                NB_S: r_us <= w_rdata[2*VW-1:VW];
                NB_N: r_un <= w_rdata[2*VW-1:VW];
                default: ;
            endcase
        end
    end

    // stage a: square, coefficient products and beta (uses u; un latched this cycle,
    // so the y product waits for stage b)
    logic signed [2*VW-1:0]  r_uu;
    logic signed [PW-1:0]    r_px, r_pc;
    logic signed [VW+RW+1:0] r_beta;
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_a) begin
            r_uu <= r_u * r_u;
            r_px <= PW'(r_cx * (VW+1)'(r_uw + r_ue));
            r_pc <= PW'(-(VW+3)'(2) * ((VW+3)'(r_cx) + (VW+3)'(r_cy)) * r_u);
            r_beta <= r_vary ? ((VW+RW+2)'(r_bb) + $signed({1'b0, w_r[RW-1:0]}) * r_bs)
                             : (VW+RW+2)'(r_bc);
        end
    end

    // stage b: cube and y product and inhibitor product
    // scaled square keeps eight integer bits more than a value
    logic signed [VW+7:0]   w_u2;
    logic signed [2*VW+7:0] r_u3p;
    logic signed [PW-1:0]   r_py;
    logic signed [PW+RW:0]  r_pv;
    assign w_u2 = (VW+8)'(r_uu >>> F);
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_b) begin
            r_u3p <= w_u2 * r_u;
            r_py  <= PW'(r_cy * (VW+1)'(r_us + r_un));
            r_pv  <= (PW+RW+1)'($signed({1'b0, EPS}) * ((VW+RW+2)'(r_u) + r_beta));
        end
    end

    // stage c: sum, round, saturate
    logic signed [VW+15:0]  w_u3;
    logic signed [AccW-1:0] w_react, w_acc;
    logic signed [AccW-1:0] w_ru_r, w_rv_r;
    logic signed [VW-1:0]   w_ru, w_rv;
    logic                   w_ou, w_ov;
    localparam logic signed [AccW-1:0] MAXV = AccW'((64'sd1 <<< (VW - 1)) - 1);
    localparam logic signed [AccW-1:0] MINV = -MAXV - 1;
    always_comb begin
        w_u3    = (VW+16)'(r_u3p >>> F);
        w_react = AccW'(3) * AccW'(r_u) - AccW'(w_u3) - AccW'(r_v);
        w_acc   = AccW'(r_px) + AccW'(r_py) + AccW'(r_pc) + (w_react <<< F);
        w_ru_r  = (w_acc + (AccW'(1) <<< (F - 1))) >>> F;
        w_rv_r  = (AccW'(r_pv) + (AccW'(1) <<< (F - 1))) >>> F;
        w_ou = 1'b0; w_ov = 1'b0;
        if (w_ru_r > MAXV) begin w_ru = MAXV[VW-1:0]; w_ou = 1'b1; end
        else if (w_ru_r < MINV) begin w_ru = MINV[VW-1:0]; w_ou = 1'b1; end
        else w_ru = w_ru_r[VW-1:0];
        if (w_rv_r > MAXV) begin w_rv = MAXV[VW-1:0]; w_ov = 1'b1; end
        else if (w_rv_r < MINV) begin w_rv = MINV[VW-1:0]; w_ov = 1'b1; end
        else w_rv = w_rv_r[VW-1:0];
    end

    // output register
    logic r_oval;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.calc_c) begin
            r_oval <= 1'b1;
        end else if (!i_out_stall) begin
            r_oval <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_c) begin
            o_rate_u   <= w_zero ? '0 : w_ru;
            o_rate_v   <= w_zero ? '0 : w_rv;
            o_overflow <= w_zero ? 1'b0 : (w_ou | w_ov);
        end
    end
    assign o_out_valid = r_oval;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("result lost");
    a_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_cell |-> !i_cmd.rd_en) else $error("write and read together");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_rate_u != '0 || o_rate_v != '0))
        else $error("overflow with zero rates");
endmodule

@@ rtl/reaction_diffusion_stencil_rate.sv @@
// Reaction-diffusion rate unit, top level: controller plus datapath.
// Write item: accepted in S_IDLE, cell written in S_RD0. Evaluate item:
// five reads in S_RD0 to S_RD4 through the single cell-memory read port,
// then S_CA, S_CB and S_CC with the chained cube multiply. One item at a time;
// stall stays high while busy and a stalled result holds the block.
// Synchronous active-low reset clears control and config; cell memory is
// undefined until written.
module reaction_diffusion_stencil_rate #(
    parameter int MAX_COLS    = rds_pkg::MAX_COLS_D,
    parameter int MAX_ROWS    = rds_pkg::MAX_ROWS_D,
    parameter int VALUE_WIDTH = rds_pkg::VALUE_WIDTH_D
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [VALUE_WIDTH-1:0]         i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [rds_pkg::COL_W-1:0]      i_col,
    input  logic [rds_pkg::ROW_W-1:0]      i_row,
    input  logic signed [VALUE_WIDTH-1:0]  i_u_value,
    input  logic signed [VALUE_WIDTH-1:0]  i_v_value,
    input  logic                           i_clamp_edges,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [VALUE_WIDTH-1:0]  o_rate_u,
    output logic signed [VALUE_WIDTH-1:0]  o_rate_v,
    output logic                           o_overflow
);
    import rds_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rds_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    rds_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_req_type(i_req_type), .i_col(i_col), .i_row(i_row),
        .i_u_value(i_u_value), .i_v_value(i_v_value), .i_clamp_edges(i_clamp_edges),
        .i_cmd(w_cmd), .o_sts(w_sts), .i_out_stall(i_stall), .o_out_valid(o_valid),
        .o_rate_u(o_rate_u), .o_rate_v(o_rate_v), .o_overflow(o_overflow)
    );
endmodule
